// ===== rtl/core/hdma_pkg.sv =====
// Shared types and constants for the video-memory DMA engine.
package hdma_pkg;

  // Request codes carried by req_type.
  typedef enum logic [1:0] {
    REQ_CTRL  = 2'd0,
    REQ_TICK  = 2'd1,
    REQ_BLANK = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  // Command kinds handed from the front to the back.
  typedef enum logic [1:0] {
    CMD_REFUSE = 2'd0,
    CMD_CTRL   = 2'd1,
    CMD_TICK   = 2'd2,
    CMD_BLANK  = 2'd3
  } cmd_kind_t;

  // Event codes reported with each result.
  localparam logic [1:0] EV_NONE      = 2'd0;
  localparam logic [1:0] EV_IGNORED   = 2'd1;
  localparam logic [1:0] EV_BANK_WARN = 2'd2;
  localparam logic [1:0] EV_BANK_SKIP = 2'd3;

  // Processor stall reported after a tick and after a block.
  localparam logic [3:0] STALL_TICK  = 4'd1;
  localparam logic [3:0] STALL_BLOCK = 4'd8;

  // Back-end sequencer states.
  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } back_state_t;

  // One classified item waiting for the back end.
  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  value;
    logic [15:0] src;
    logic [15:0] dst;
    logic        bank;
    logic        hblank;
  } cmd_t;

endpackage

// ===== rtl/core/hblank_general_dma_engine.sv =====
// Top level of the video-memory DMA engine: front end, command queue, back end.
//
//   Channel   Handshake               Carries
//   cfg       cfg_valid / cfg_ready   color_mode_enable
//   in        in_valid / in_ready     req_type, control_value, src_start,
//                                     dst_start, current_bank, in_hblank
//   out       out_valid / out_ready   copy_valid, src_addr, dst_addr, status_valid,
//                                     status_byte, stall_cycles, event_code, last
//
// The back end dispatches a queued item, then sends one result per copied byte
// through its single output register; a refused, ignored, skipped or stop item
// gives a single result.
// The front end accepts an item each cycle while the two-entry queue has room.
// Reset is synchronous; no clearing pass follows it.
// A stalled output holds the back end; the queue then fills and in_ready drops.
module hblank_general_dma_engine #(
  parameter int BLOCK_BYTES = 16,
  parameter int TICK_BYTES  = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        color_mode_enable,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [7:0]  control_value,
  input  logic [15:0] src_start,
  input  logic [15:0] dst_start,
  input  logic        current_bank,
  input  logic        in_hblank,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        copy_valid,
  output logic [15:0] src_addr,
  output logic [15:0] dst_addr,
  output logic        status_valid,
  output logic [7:0]  status_byte,
  output logic [3:0]  stall_cycles,
  output logic [1:0]  event_code,
  output logic        last
);
  import hdma_pkg::*;

  logic q_space;
  logic push;
  cmd_t push_cmd;
  logic head_valid;
  cmd_t head_cmd;
  logic pop;

  // Classification of items and the enable register.
  hdma_front u_front (
    .clk               (clk),
    .rst               (rst),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .color_mode_enable (color_mode_enable),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .req_type          (req_type),
    .control_value     (control_value),
    .src_start         (src_start),
    .dst_start         (dst_start),
    .current_bank      (current_bank),
    .in_hblank         (in_hblank),
    .q_space           (q_space),
    .push              (push),
    .push_cmd          (push_cmd)
  );

  // Decoupling queue.
  hdma_cmdq #(
    .DEPTH (2)
  ) u_cmdq (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .space      (q_space),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop)
  );

  // Transfer execution.
  hdma_back #(
    .BLOCK_BYTES (BLOCK_BYTES),
    .TICK_BYTES  (TICK_BYTES)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head_cmd     (head_cmd),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .copy_valid   (copy_valid),
    .src_addr     (src_addr),
    .dst_addr     (dst_addr),
    .status_valid (status_valid),
    .status_byte  (status_byte),
    .stall_cycles (stall_cycles),
    .event_code   (event_code),
    .last         (last)
  );

endmodule

// ===== rtl/core/hdma_front.sv =====
// Front end: holds the enable register and classifies incoming items.
module hdma_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               color_mode_enable,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         req_type,
  input  logic [7:0]         control_value,
  input  logic [15:0]        src_start,
  input  logic [15:0]        dst_start,
  input  logic               current_bank,
  input  logic               in_hblank,
  input  logic               q_space,
  output logic               push,
  output hdma_pkg::cmd_t     push_cmd
);
  import hdma_pkg::*;

  logic mode_en;
  logic keep;

  // Enable register; writes are taken at any time.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_en <= 1'b0;
    end else if (cfg_valid) begin
      mode_en <= color_mode_enable;
    end
  end

  // Items with no request, and ticks and blanks while disabled, are dropped here.
  assign in_ready = q_space;

  always_comb begin
    unique case (req_type)
      REQ_CTRL:  keep = 1'b1;
      REQ_TICK:  keep = mode_en;
      REQ_BLANK: keep = mode_en;
      default:   keep = 1'b0;
    endcase
  end

  assign push = in_valid && in_ready && keep;

  // Map the request to a command; a control write while disabled is refused.
  always_comb begin
    push_cmd.value  = control_value;
    push_cmd.src    = src_start;
    push_cmd.dst    = dst_start;
    push_cmd.bank   = current_bank;
    push_cmd.hblank = in_hblank;
    if (!mode_en) begin
      push_cmd.kind = CMD_REFUSE;
    end else begin
      unique case (req_type)
        REQ_TICK:  push_cmd.kind = CMD_TICK;
        REQ_BLANK: push_cmd.kind = CMD_BLANK;
        default:   push_cmd.kind = CMD_CTRL;
      endcase
    end
  end

endmodule

// ===== rtl/core/hdma_cmdq.sv =====
// Short command queue between the front end and the back end.
module hdma_cmdq #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  hdma_pkg::cmd_t  push_cmd,
  output logic            space,
  output logic            head_valid,
  output hdma_pkg::cmd_t  head_cmd,
  input  logic            pop
);
  import hdma_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign space      = (count != CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = entries[rd_ptr];

  // Entry storage; payload needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/hdma_back.sv =====
// Back end: transfer state, byte sequencer and output register.
module hdma_back #(
  parameter int BLOCK_BYTES = 16,
  parameter int TICK_BYTES  = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            head_valid,
  input  hdma_pkg::cmd_t  head_cmd,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic            copy_valid,
  output logic [15:0]     src_addr,
  output logic [15:0]     dst_addr,
  output logic            status_valid,
  output logic [7:0]      status_byte,
  output logic [3:0]      stall_cycles,
  output logic [1:0]      event_code,
  output logic            last
);
  import hdma_pkg::*;

  localparam int RUN_MAX = (BLOCK_BYTES > TICK_BYTES) ? BLOCK_BYTES : TICK_BYTES;
  localparam int RUN_W   = $clog2(RUN_MAX + 1);
  localparam int REM_W   = $clog2(BLOCK_BYTES + 1);

  // Transfer state. Bytes left is kept as blocks left, the current one included,
  // plus bytes left in the current block, so the status needs no division.
  back_state_t      state, state_next;
  logic [15:0]      src_ptr, src_ptr_next;
  logic [15:0]      dst_ptr, dst_ptr_next;
  logic [7:0]       blocks, blocks_next;
  logic [REM_W-1:0] rem, rem_next;
  logic             start_bank, start_bank_next;
  logic             active, active_next;
  logic             blank_mode, blank_mode_next;
  logic [RUN_W-1:0] run_left, run_left_next;
  logic [3:0]       run_stall, run_stall_next;
  logic [1:0]       run_ev, run_ev_next;

  // Output register loading.
  logic        out_free;
  logic        load;
  logic        copy_valid_next;
  logic [15:0] src_addr_next;
  logic [15:0] dst_addr_next;
  logic        status_valid_next;
  logic [7:0]  status_byte_next;
  logic [3:0]  stall_cycles_next;
  logic [1:0]  event_code_next;
  logic        last_next;

  // Helpers for one copied byte.
  logic has_bytes;
  logic final_byte;
  logic run_end;

  assign out_free   = !out_valid || out_ready;
  assign has_bytes  = (blocks != '0);
  assign final_byte = (blocks == 8'd1) && (rem == REM_W'(1));
  assign run_end    = (run_left == RUN_W'(1)) || final_byte || !has_bytes;

  // Dispatch of queued commands and byte sequencing.
  always_comb begin
    state_next        = state;
    src_ptr_next      = src_ptr;
    dst_ptr_next      = dst_ptr;
    blocks_next       = blocks;
    rem_next          = rem;
    start_bank_next   = start_bank;
    active_next       = active;
    blank_mode_next   = blank_mode;
    run_left_next     = run_left;
    run_stall_next    = run_stall;
    run_ev_next       = run_ev;
    pop               = 1'b0;
    load              = 1'b0;
    copy_valid_next   = 1'b0;
    src_addr_next     = '0;
    dst_addr_next     = '0;
    status_valid_next = 1'b0;
    status_byte_next  = '0;
    stall_cycles_next = '0;
    event_code_next   = EV_NONE;
    last_next         = 1'b0;

    unique case (state)
      BK_IDLE: begin
        if (head_valid && out_free) begin
          pop = 1'b1;
          unique case (head_cmd.kind)
            CMD_REFUSE: begin
              load            = 1'b1;
              event_code_next = EV_IGNORED;
              last_next       = 1'b1;
            end
            CMD_CTRL: begin
              if (active && head_cmd.value[7]) begin
                load            = 1'b1;
                event_code_next = EV_IGNORED;
                last_next       = 1'b1;
              end else if (active) begin
                // Stop: the written value becomes the status.
                active_next       = 1'b0;
                load              = 1'b1;
                status_valid_next = 1'b1;
                status_byte_next  = head_cmd.value;
                last_next         = 1'b1;
              end else begin
                // Start a new transfer.
                src_ptr_next    = head_cmd.src;
                dst_ptr_next    = head_cmd.dst;
                blocks_next     = {1'b0, head_cmd.value[6:0]} + 8'd1;
                rem_next        = REM_W'(BLOCK_BYTES);
                start_bank_next = head_cmd.bank;
                active_next     = 1'b1;
                blank_mode_next = head_cmd.value[7];
                if (head_cmd.value[7] && head_cmd.hblank) begin
                  state_next     = BK_RUN;
                  run_left_next  = RUN_W'(BLOCK_BYTES);
                  run_stall_next = STALL_BLOCK;
                  run_ev_next    = EV_NONE;
                end
              end
            end
            CMD_TICK: begin
              if (active && !blank_mode) begin
                state_next     = BK_RUN;
                run_left_next  = RUN_W'(TICK_BYTES);
                run_stall_next = STALL_TICK;
                run_ev_next    = (head_cmd.bank != start_bank) ? EV_BANK_WARN : EV_NONE;
              end
            end
            default: begin
              if (active && blank_mode) begin
                if (head_cmd.bank != start_bank) begin
                  load            = 1'b1;
                  event_code_next = EV_BANK_SKIP;
                  last_next       = 1'b1;
                end else begin
                  state_next     = BK_RUN;
                  run_left_next  = RUN_W'(BLOCK_BYTES);
                  run_stall_next = STALL_BLOCK;
                  run_ev_next    = EV_NONE;
                end
              end
            end
          endcase
        end
      end
      default: begin
        // One byte per cycle while the output is free; status and stall ride on the final result.
        if (out_free) begin
          load            = 1'b1;
          copy_valid_next = has_bytes;
          event_code_next = run_ev;
          if (has_bytes) begin
            src_addr_next = src_ptr;
            dst_addr_next = dst_ptr;
            src_ptr_next  = src_ptr + 16'd1;
            dst_ptr_next  = dst_ptr + 16'd1;
            if (rem == REM_W'(1)) begin
              blocks_next = blocks - 8'd1;
              rem_next    = REM_W'(BLOCK_BYTES);
            end else begin
              rem_next = rem - 1'b1;
            end
          end
          run_left_next = run_left - 1'b1;
          if (run_end) begin
            state_next        = BK_IDLE;
            status_valid_next = 1'b1;
            status_byte_next  = blocks_next - 8'd1;
            stall_cycles_next = run_stall;
            last_next         = 1'b1;
            if (blocks_next == '0) begin
              active_next = 1'b0;
            end
          end
        end
      end
    endcase
  end

  // Sequencer and transfer state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= BK_IDLE;
      active     <= 1'b0;
      blank_mode <= 1'b0;
      start_bank <= 1'b0;
      blocks     <= '0;
      rem        <= '0;
      src_ptr    <= '0;
      dst_ptr    <= '0;
    end else begin
      state      <= state_next;
      active     <= active_next;
      blank_mode <= blank_mode_next;
      start_bank <= start_bank_next;
      blocks     <= blocks_next;
      rem        <= rem_next;
      src_ptr    <= src_ptr_next;
      dst_ptr    <= dst_ptr_next;
    end
  end

  // Run parameters are payload and need no reset.
  always_ff @(posedge clk) begin
    run_left  <= run_left_next;
    run_stall <= run_stall_next;
    run_ev    <= run_ev_next;
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (load) begin
      copy_valid   <= copy_valid_next;
      src_addr     <= src_addr_next;
      dst_addr     <= dst_addr_next;
      status_valid <= status_valid_next;
      status_byte  <= status_byte_next;
      stall_cycles <= stall_cycles_next;
      event_code   <= event_code_next;
      last         <= last_next;
    end
  end

endmodule
